### rtl/multichannel_moving_average_macros.svh
// Assertion macros shared by the moving-average RTL.
`ifndef MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH
`define MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication, checked on clk, off while arst_n is low.
`define MMA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off while arst_n is low.
`define MMA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/mma_pkg.sv
// Package: item types and fixed field widths of the moving-average block.
`timescale 1ns / 1ps

package mma_pkg;

	localparam int CHAN_W   = 5;
	localparam int SAMPLE_W = 16;

	typedef struct packed {
		logic [CHAN_W-1:0]   channel;
		logic [SAMPLE_W-1:0] sample;
	} sample_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0]   channel_out;
		logic [SAMPLE_W-1:0] average;
	} result_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic              in_range;
	} mean_tag_t;

endpackage

### rtl/mma_stream_if.sv
// Interface: valid/ready stream channel carrying one item.
`timescale 1ns / 1ps

interface mma_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

### rtl/multichannel_moving_average.sv
// Top level: multichannel boxcar moving-average filter.
// samples (sink): one item per channel sample, fields channel and sample.
// averages (source): one item per accepted sample, fields channel_out and
//   average = floor(sum of the last WINDOW samples of that channel / WINDOW).
// The first sample on a channel stands for a full window of that value.
// A channel at or above CHANNELS leaves all state alone and reports zero.
// Throughput: one item per cycle, sustained while averages takes results; set by the single read,
//   modify and write-back of the per-channel sum memory each cycle, with
//   forwarding of the last written entry to the next read.
// Path: accept, s1 (memory data back), s2, s3 (product), output register, then averages.
// Each channel's window lives in one RAM, its running sum and first
//   value in another; primed, wrap and ring pointer bits are flops.
// Reset clears primed flags and pointers at once; no clearing pass, the
//   block takes items from the first cycle after reset.
// When averages stalls, results queue in the pipeline stages; samples.ready
//   drops only once every stage holds an item.
`timescale 1ns / 1ps
`include "multichannel_moving_average_macros.svh"

module multichannel_moving_average #(
	parameter int WINDOW   = 16,
	parameter int CHANNELS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	mma_stream_if.sink   samples,
	mma_stream_if.source averages
);

	localparam int PTR_W   = $clog2(WINDOW);
	localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SMP_W   = mma_pkg::SAMPLE_W;
	localparam int CH_W    = mma_pkg::CHAN_W;
	localparam int SUM_W   = SMP_W + PTR_W;
	localparam int CRAM_W  = SUM_W + SMP_W;
	localparam int CRAM_D  = 2 ** IDX_W;
	localparam int WRAM_AW = IDX_W + PTR_W;
	localparam int WRAM_D  = 2 ** WRAM_AW;

	// accept stage
	logic             fire;
	logic             in_range;
	logic [IDX_W-1:0] ch_idx;
	logic             cur_primed;
	logic             cur_wrapped;
	logic [PTR_W-1:0] cur_ptr;

	logic [CHANNELS-1:0] primed_q;
	logic [CHANNELS-1:0] wrapped_q;
	logic [PTR_W-1:0]    ptr_q [CHANNELS];

	// s1: memory data back
	logic             v1_q;
	logic [CH_W-1:0]  ch_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [SMP_W-1:0] smp_s1;
	logic             inr_s1;
	logic             prm_s1;
	logic             wrp_s1;
	logic [PTR_W-1:0] ptr_s1;

	logic [CRAM_W-1:0] cram_rdata;
	logic [SMP_W-1:0]  wram_rdata;
	logic              fwd;
	logic [SUM_W-1:0]  cur_sum;
	logic [SMP_W-1:0]  cur_pval;
	logic [SMP_W-1:0]  old_smp;
	logic [SUM_W-1:0]  new_sum;
	logic [SMP_W-1:0]  new_pval;
	logic              wr;

	// last written sum-memory entry
	logic             lw_v_q;
	logic [IDX_W-1:0] lw_idx_q;
	logic [SUM_W-1:0] lw_sum_q;
	logic [SMP_W-1:0] lw_pval_q;

	// s2
	logic               v2_q;
	mma_pkg::mean_tag_t tag_s2;
	logic [SUM_W-1:0]   sum_s2;
	logic               mean_ready;
	logic               en1;
	logic               en2;

	assign en2           = !v2_q || mean_ready;
	assign en1           = !v1_q || en2;
	assign samples.ready = en1;
	assign fire          = samples.valid && en1;

	assign in_range    = (9'(samples.data.channel) < 9'(CHANNELS));
	assign ch_idx      = IDX_W'(samples.data.channel);
	assign cur_primed  = in_range && primed_q[ch_idx];
	assign cur_wrapped = wrapped_q[ch_idx];
	assign cur_ptr     = ptr_q[ch_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q  <= '0;
			wrapped_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				ptr_q[i] <= '0;
			end
		end else if (fire && in_range) begin
			primed_q[ch_idx] <= 1'b1;
			if (!cur_primed) begin
				ptr_q[ch_idx]     <= '0;
				wrapped_q[ch_idx] <= 1'b0;
			end else if (cur_ptr == PTR_W'(WINDOW - 1)) begin
				ptr_q[ch_idx]     <= '0;
				wrapped_q[ch_idx] <= 1'b1;
			end else begin
				ptr_q[ch_idx] <= cur_ptr + 1'b1;
			end
		end
	end

	mma_ram #(
		.WIDTH (CRAM_W),
		.DEPTH (CRAM_D)
	) u_sum_ram (
		.clk   (clk),
		.we    (wr),
		.waddr (idx_s1),
		.wdata ({new_sum, new_pval}),
		.re    (fire),
		.raddr (ch_idx),
		.rdata (cram_rdata)
	);

	mma_ram #(
		.WIDTH (SMP_W),
		.DEPTH (WRAM_D)
	) u_window_ram (
		.clk   (clk),
		.we    (wr && prm_s1),
		.waddr ({idx_s1, ptr_s1}),
		.wdata (smp_s1),
		.re    (fire),
		.raddr ({ch_idx, cur_ptr}),
		.rdata (wram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q   <= 1'b0;
			v2_q   <= 1'b0;
			lw_v_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= samples.valid;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (wr) begin
				lw_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ch_s1  <= samples.data.channel;
			idx_s1 <= ch_idx;
			smp_s1 <= samples.data.sample;
			inr_s1 <= in_range;
			prm_s1 <= cur_primed;
			wrp_s1 <= cur_wrapped;
			ptr_s1 <= cur_ptr;
		end
		if (wr) begin
			lw_idx_q  <= idx_s1;
			lw_sum_q  <= new_sum;
			lw_pval_q <= new_pval;
		end
		if (en2) begin
			tag_s2.channel  <= ch_s1;
			tag_s2.in_range <= inr_s1;
			sum_s2          <= new_sum;
		end
	end

	// read-modify-write of the running sum
	assign fwd      = lw_v_q && (lw_idx_q == idx_s1);
	assign cur_sum  = fwd ? lw_sum_q : cram_rdata[CRAM_W-1 -: SUM_W];
	assign cur_pval = fwd ? lw_pval_q : cram_rdata[SMP_W-1:0];
	assign old_smp  = wrp_s1 ? wram_rdata : cur_pval;
	assign new_sum  = prm_s1 ? (cur_sum - SUM_W'(old_smp) + SUM_W'(smp_s1))
		: (SUM_W'(smp_s1) * SUM_W'(WINDOW));
	assign new_pval = prm_s1 ? cur_pval : smp_s1;
	assign wr       = v1_q && en2 && inr_s1;

	mma_mean #(
		.WINDOW (WINDOW)
	) u_mean (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v2_q),
		.in_ready (mean_ready),
		.in_tag   (tag_s2),
		.in_sum   (sum_s2),
		.averages (averages)
	);

	`MMA_ASSERT_NEXT(a_accept_to_s1, fire, v1_q, "accepted item missing in s1")
	`MMA_ASSERT_NEXT(a_s1_hold, v1_q && !en2, v1_q && $stable(smp_s1) && $stable(idx_s1), "s1 item lost in stall")
	`MMA_ASSERT_NEXT(a_prime_ptr, fire && in_range && !cur_primed, primed_q[$past(ch_idx)] && (ptr_q[$past(ch_idx)] == '0), "priming did not reset ring pointer")

endmodule

### rtl/mma_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module mma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/mma_mean.sv
// Mean stage: window sum times reciprocal of the window length, then output register.
`timescale 1ns / 1ps
`include "multichannel_moving_average_macros.svh"

module mma_mean #(
	parameter int WINDOW = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         in_valid,
	output logic                                         in_ready,
	input  mma_pkg::mean_tag_t                           in_tag,
	input  logic [mma_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] in_sum,
	mma_stream_if.source                                 averages
);

	localparam int PTR_W  = $clog2(WINDOW);
	localparam int SUM_W  = mma_pkg::SAMPLE_W + PTR_W;
	localparam int SHIFT  = SUM_W + PTR_W;
	localparam int MUL_W  = SUM_W + 1;
	localparam int PROD_W = SUM_W + MUL_W;
	localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(WINDOW) - 1)
		/ longint'(WINDOW);
	localparam logic [MUL_W-1:0] RECIP = MUL_W'(RECIP_L);

	logic               v3_q;
	mma_pkg::mean_tag_t tag_s3;
	logic [PROD_W-1:0]  prod_s3;
	logic               vo_q;
	mma_pkg::result_item_t out_q;
	logic               en_o;
	logic               en3;

	assign en_o     = !vo_q || averages.ready;
	assign en3      = !v3_q || en_o;
	assign in_ready = en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (en3) begin
				v3_q <= in_valid;
			end
			if (en_o) begin
				vo_q <= v3_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			tag_s3  <= in_tag;
			prod_s3 <= PROD_W'(in_sum) * PROD_W'(RECIP);
		end
		if (en_o) begin
			out_q.channel_out <= tag_s3.channel;
			out_q.average     <= tag_s3.in_range ? prod_s3[SHIFT +: mma_pkg::SAMPLE_W]
				: '0;
		end
	end

	assign averages.valid = vo_q;
	assign averages.data  = out_q;

	`MMA_ASSERT_NEXT(a_s3_hold, v3_q && !en_o, v3_q && $stable(prod_s3), "s3 item lost in stall")

endmodule

### verif/mma_checker.sv
// Checker: predicts each channel's window average and compares it with the block's results.
`timescale 1ns / 1ps

module mma_checker #(
	parameter int WINDOW   = 16,
	parameter int CHANNELS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	input  logic                  sample_ready,
	input  mma_pkg::sample_item_t sample_data,
	input  logic                  average_valid,
	input  logic                  average_ready,
	input  mma_pkg::result_item_t average_data,
	output int                    errors,
	output int                    pending,
	output int                    checked
);

	localparam int MAX_REPORTS = 10;

	logic [mma_pkg::SAMPLE_W-1:0] history [CHANNELS][WINDOW];
	logic                         primed [CHANNELS];
	logic [31:0]                  running_sum [CHANNELS];
	int unsigned                  oldest_pos [CHANNELS];
	mma_pkg::result_item_t        expected_averages [$];

	function automatic mma_pkg::result_item_t predict_average(mma_pkg::sample_item_t it);
		mma_pkg::result_item_t res;
		int ch;
		int unsigned pos;
		ch = int'(it.channel);
		res.channel_out = it.channel;
		res.average = '0;
		if (ch < CHANNELS) begin
			if (!primed[ch]) begin
				for (int i = 0; i < WINDOW; i++)
					history[ch][i] = it.sample;
				running_sum[ch] = 32'(it.sample) * WINDOW;
				oldest_pos[ch] = 0;
				primed[ch] = 1'b1;
			end else begin
				pos = oldest_pos[ch];
				running_sum[ch] = running_sum[ch] - 32'(history[ch][pos]) + 32'(it.sample);
				history[ch][pos] = it.sample;
				oldest_pos[ch] = (pos + 1) % WINDOW;
			end
			res.average = mma_pkg::SAMPLE_W'(running_sum[ch] / WINDOW);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mma_pkg::result_item_t exp_res;
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				primed[c] = 1'b0;
				running_sum[c] = '0;
				oldest_pos[c] = 0;
				for (int i = 0; i < WINDOW; i++)
					history[c][i] = '0;
			end
			expected_averages.delete();
			errors = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (average_valid && average_ready) begin
				if (expected_averages.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected average item: channel %0d average %0d",
							$time, average_data.channel_out, average_data.average);
				end else begin
					exp_res = expected_averages.pop_front();
					checked++;
					if (average_data.channel_out !== exp_res.channel_out ||
						average_data.average !== exp_res.average) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: mismatch: channel exp %0d got %0d, average exp %0d got %0d",
								$time, exp_res.channel_out, average_data.channel_out,
								exp_res.average, average_data.average);
					end
				end
			end
			if (sample_valid && sample_ready)
				expected_averages.push_back(predict_average(sample_data));
			pending = expected_averages.size();
		end
	end

endmodule

### verif/tb.sv
// Testbench top: clock, reset, sample stimulus with idle patterns, and the verdict.
`timescale 1ns / 1ps

module tb;

	localparam int WINDOW           = 16;
	localparam int CHANNELS         = 32;
	localparam int RANDOM_PER_PHASE = 626;
	localparam int DRAIN_CYCLES     = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   send_idle = 0;
	int   recv_idle = 0;
	int   sent = 0;
	int   errors;
	int   pending;
	int   checked;
	int   send_pattern [3] = '{15, 51, 0};
	int   recv_pattern [3] = '{51, 15, 0};

	mma_stream_if #(.payload_t(mma_pkg::sample_item_t)) samples_if ();
	mma_stream_if #(.payload_t(mma_pkg::result_item_t)) averages_if ();

	multichannel_moving_average #(
		.WINDOW(WINDOW),
		.CHANNELS(CHANNELS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.averages(averages_if)
	);

	mma_checker #(
		.WINDOW(WINDOW),
		.CHANNELS(CHANNELS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(samples_if.valid),
		.sample_ready(samples_if.ready),
		.sample_data(samples_if.data),
		.average_valid(averages_if.valid),
		.average_ready(averages_if.ready),
		.average_data(averages_if.data),
		.errors(errors),
		.pending(pending),
		.checked(checked)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		averages_if.ready <= ($urandom_range(99) >= recv_idle);
	end

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic send_sample(input logic [mma_pkg::CHAN_W-1:0] ch,
		input logic [mma_pkg::SAMPLE_W-1:0] smp);
		mma_pkg::sample_item_t it;
		it.channel = ch;
		it.sample = smp;
		while ($urandom_range(99) < send_idle) begin
			samples_if.valid <= 1'b0;
			@(negedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.data <= it;
		do @(posedge clk); while (!samples_if.ready);
		sent++;
		@(negedge clk);
	endtask

	function automatic mma_pkg::sample_item_t random_sample();
		mma_pkg::sample_item_t it;
		int pick;
		pick = $urandom_range(99);
		if (pick < 40)
			it.channel = mma_pkg::CHAN_W'($urandom_range(3));
		else
			it.channel = mma_pkg::CHAN_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 10)
			it.sample = '0;
		else if (pick < 20)
			it.sample = '1;
		else if (pick < 30)
			it.sample = mma_pkg::SAMPLE_W'(16'hFFFF - $urandom_range(15));
		else
			it.sample = mma_pkg::SAMPLE_W'($urandom);
		return it;
	endfunction

	initial begin
		mma_pkg::sample_item_t it;
		samples_if.valid = 1'b0;
		samples_if.data = '0;
		averages_if.ready = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		send_idle = send_pattern[0];
		recv_idle = recv_pattern[0];
		// first samples prime channels 0, 31, 1 and 2, the first two at the field extremes
		send_sample(5'd0, 16'h0000);
		send_sample(5'd31, 16'hFFFF);
		send_sample(5'd1, 16'h5555);
		send_sample(5'd2, 16'hAAAA);
		// walk channel 31 down to zero through a full window and past the wrap
		repeat (WINDOW + 1) send_sample(5'd31, 16'h0000);
		send_sample(5'd0, 16'hFFFF);
		send_sample(5'd0, 16'hFFFF);

		for (int p = 0; p < 3; p++) begin
			send_idle = send_pattern[p];
			recv_idle = recv_pattern[p];
			repeat (RANDOM_PER_PHASE) begin
				it = random_sample();
				send_sample(it.channel, it.sample);
			end
		end
		samples_if.valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d samples on all %0d channels under three idle patterns;", sent, CHANNELS);
		$display("checked %0d window averages, %0d errors.", checked, errors);
		if (errors == 0)
			$display("multichannel_moving_average test passed");
		else
			$display("multichannel_moving_average test failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d averages outstanding", pending);
		$display("multichannel_moving_average test failed");
		$finish;
	end

endmodule
